// ===== hw/rtl/tws_pkg.sv =====
// Shared types, codes and constants for the three-wire serial master.
`timescale 1ns / 1ps

package tws_pkg;

    // Bytes moved by a burst access.
    localparam int BURST_BYTES = 8;

    // Enough bits to count the command byte plus every data byte and one more.
    localparam int BYTE_W = $clog2(BURST_BYTES + 2);

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;
    localparam logic [4:0] BURST_ADDRESS     = 5'd31;

    localparam logic [2:0] CMD_NONE         = 3'd0;
    localparam logic [2:0] CMD_READ_SINGLE  = 3'd1;
    localparam logic [2:0] CMD_WRITE_SINGLE = 3'd2;
    localparam logic [2:0] CMD_READ_BURST   = 3'd3;
    localparam logic [2:0] CMD_WRITE_BURST  = 3'd4;

    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_GAP
    } phase_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       data_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic       last;
        logic       busy_res;
    } result_t;

endpackage

// ===== hw/rtl/three_wire_rtc_serial_master.sv =====
// An accepted tick request has its result in the output register in the next cycle.
// Throughput: one tick request per cycle while results are taken; the output register lets
// a new request enter in the same cycle that the waiting result is taken.
// Reset: rst_n clears the transaction state, empties the output register and sets
// phase_ticks back to 2.
`timescale 1ns / 1ps

module three_wire_rtc_serial_master (
    input  logic        clk,
    input  logic        rst_n,
    // APB-style configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Tick request channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic        ram_select,
    input  logic [4:0]  address,
    input  logic [7:0]  write_data,
    input  logic        io_in,
    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic        chip_enable,
    output logic        serial_clock,
    output logic        io_out,
    output logic        io_drive,
    output logic        data_taken,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        last,
    output logic        busy_res
);
    import tws_pkg::*;

    logic [7:0] phase_ticks_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    step_res;
    logic       accept;

    // The only register is phase_ticks at byte address zero. It sets how many
    // ticks each half of the serial clock lasts.
    assign pready = 1'b1;

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == REG_PHASE_TICKS)
        begin
            prdata = {24'd0, phase_ticks_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == REG_PHASE_TICKS))
        begin
            phase_ticks_reg <= pwdata[7:0];
        end
    end

    // A request is taken whenever the output register is empty or is being emptied
    // in this same cycle; while results are taken, the waveform advances one tick per cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // The engine holds the transaction state and works out this tick's pin
    // levels; its state only moves on an accepted request.
    tws_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .phase_ticks (phase_ticks_reg),
        .command     (command),
        .ram_select  (ram_select),
        .address     (address),
        .write_data  (write_data),
        .io_in       (io_in),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= step_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chip_enable  = result_reg.chip_enable;
    assign serial_clock = result_reg.serial_clock;
    assign io_out       = result_reg.io_out;
    assign io_drive     = result_reg.io_drive;
    assign data_taken   = result_reg.data_taken;
    assign read_valid   = result_reg.read_valid;
    assign read_data    = result_reg.read_data;
    assign last         = result_reg.last;
    assign busy_res     = result_reg.busy_res;

endmodule

// ===== hw/rtl/tws_engine.sv =====
// Bit engine: transaction state and the per-tick pin waveform logic.
`timescale 1ns / 1ps

module tws_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       phase_ticks,
    input  logic [2:0]       command,
    input  logic             ram_select,
    input  logic [4:0]       address,
    input  logic [7:0]       write_data,
    input  logic             io_in,
    output tws_pkg::result_t res
);
    import tws_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [7:0]        tick_count_reg, tick_count_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        receive_reg, receive_next;
    logic [2:0]        operation_reg, operation_next;

    // Values seen this tick, after a command has possibly started a transaction.
    logic              start;
    phase_t            cur_phase;
    logic [2:0]        cur_op;
    logic [7:0]        cur_tick;
    logic [2:0]        cur_bit;
    logic [BYTE_W-1:0] cur_byte;
    logic [7:0]        cur_shift;
    logic [7:0]        cur_recv;
    logic              op_reads;
    logic              op_burst;
    logic              reading;
    logic [7:0]        limit;
    logic              done;
    logic              byte_end;
    logic [BYTE_W-1:0] byte_inc;
    logic [BYTE_W-1:0] total;
    logic              is_last;
    logic [4:0]        cmd_addr;
    logic [7:0]        cmd_byte;

    assign start = (phase_reg == PH_IDLE)
                && (command inside {[CMD_READ_SINGLE:CMD_WRITE_BURST]});

    assign cur_op = start ? command : operation_reg;
    assign op_reads = (cur_op == CMD_READ_SINGLE) || (cur_op == CMD_READ_BURST);
    assign op_burst = (cur_op == CMD_READ_BURST) || (cur_op == CMD_WRITE_BURST);

    assign cmd_addr = op_burst ? BURST_ADDRESS : address;
    assign cmd_byte = {1'b1, ram_select, cmd_addr, op_reads};

    assign cur_phase = start ? PH_LOW : phase_reg;
    assign cur_tick  = start ? 8'd0 : tick_count_reg;
    assign cur_bit   = start ? 3'd0 : bit_index_reg;
    assign cur_byte  = start ? '0 : byte_index_reg;
    assign cur_shift = start ? cmd_byte : shift_reg;
    assign cur_recv  = start ? 8'd0 : receive_reg;

    assign reading  = op_reads && (cur_byte != '0);
    assign limit    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    assign done     = ({1'b0, cur_tick} + 9'd1) >= {1'b0, limit};
    assign byte_end = (cur_phase == PH_HIGH) && done && (cur_bit == 3'd7);
    assign byte_inc = cur_byte + BYTE_W'(1);
    assign total    = op_burst ? BYTE_W'(BURST_BYTES) : BYTE_W'(1);
    assign is_last  = byte_inc > total;

    // Next state.
    always_comb
    begin
        phase_next      = cur_phase;
        tick_count_next = cur_tick;
        bit_index_next  = cur_bit;
        byte_index_next = cur_byte;
        shift_next      = cur_shift;
        receive_next    = cur_recv;
        operation_next  = cur_op;
        case (cur_phase)
            PH_GAP:
            begin
                phase_next = PH_IDLE;
            end
            PH_LOW:
            begin
                if (done)
                begin
                    if (reading && io_in)
                    begin
                        receive_next = cur_recv | (8'd1 << cur_bit);
                    end
                    phase_next      = PH_HIGH;
                    tick_count_next = 8'd0;
                end
                else
                begin
                    tick_count_next = cur_tick + 8'd1;
                end
            end
            PH_HIGH:
            begin
                if (done)
                begin
                    tick_count_next = 8'd0;
                    phase_next      = PH_LOW;
                    shift_next      = {1'b0, cur_shift[7:1]};
                    bit_index_next  = cur_bit + 3'd1;
                    if (byte_end)
                    begin
                        if (reading)
                        begin
                            receive_next = 8'd0;
                        end
                        byte_index_next = byte_inc;
                        if (is_last)
                        begin
                            phase_next     = PH_GAP;
                            operation_next = CMD_NONE;
                        end
                        else if (!op_reads)
                        begin
                            shift_next = write_data;
                        end
                    end
                end
                else
                begin
                    tick_count_next = cur_tick + 8'd1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Pin levels and flags for this tick.
    always_comb
    begin
        res = '0;
        case (cur_phase)
            PH_GAP:
            begin
                res.busy_res = 1'b1;
            end
            PH_LOW, PH_HIGH:
            begin
                res.chip_enable  = 1'b1;
                res.busy_res     = 1'b1;
                res.io_drive     = !reading;
                res.io_out       = !reading && cur_shift[0];
                res.serial_clock = (cur_phase == PH_HIGH);
                if (byte_end)
                begin
                    res.read_valid = reading;
                    res.read_data  = reading ? cur_recv : 8'd0;
                    res.last       = is_last;
                    res.data_taken = !is_last && !op_reads;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= 8'd0;
            bit_index_reg  <= 3'd0;
            byte_index_reg <= '0;
            shift_reg      <= 8'd0;
            receive_reg    <= 8'd0;
            operation_reg  <= CMD_NONE;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            byte_index_reg <= byte_index_next;
            shift_reg      <= shift_next;
            receive_reg    <= receive_next;
            operation_reg  <= operation_next;
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the three-wire serial master: tick requests in, pin results out.
`timescale 1ns / 1ps

module tb;
    import tws_pkg::*;

    // Command codes above the defined set; the block must treat them as no command.
    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

    // Longest run of cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        logic [2:0] command;
        logic       ram_select;
        logic [4:0] address;
        logic [7:0] write_data;
        logic       io_in;
    } tick_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  command = CMD_NONE;
    logic        ram_select = 1'b0;
    logic [4:0]  address = '0;
    logic [7:0]  write_data = '0;
    logic        io_in = 1'b0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        chip_enable;
    logic        serial_clock;
    logic        io_out;
    logic        io_drive;
    logic        data_taken;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        last;
    logic        busy_res;

    three_wire_rtc_serial_master DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .ram_select   (ram_select),
        .address      (address),
        .write_data   (write_data),
        .io_in        (io_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .chip_enable  (chip_enable),
        .serial_clock (serial_clock),
        .io_out       (io_out),
        .io_drive     (io_drive),
        .data_taken   (data_taken),
        .read_valid   (read_valid),
        .read_data    (read_data),
        .last         (last),
        .busy_res     (busy_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Pending tick requests and the pin levels expected for the requests already accepted.
    tick_t   tick_queue[$];
    result_t expected_pins[$];

    // Our own copy of the waveform sequencer and its phase_ticks register.
    logic [7:0] cfg_phase_ticks = PHASE_TICKS_RESET;
    phase_t     pin_phase = PH_IDLE;
    logic [7:0] pin_tick = '0;
    logic [2:0] pin_bit = '0;
    logic [7:0] pin_byte = '0;
    logic [7:0] pin_shift = '0;
    logic [7:0] pin_rx = '0;
    logic [2:0] pin_op = CMD_NONE;

    int src_idle_pct = 20;
    int snk_idle_pct = 20;
    int src_gap = 0;
    int snk_gap = 0;
    int stall_cycles = 0;
    int errors = 0;
    int queued_ticks = 0;
    int results_seen = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_bursts = 0;

    function automatic logic is_read(input logic [2:0] op);
        return op == CMD_READ_SINGLE || op == CMD_READ_BURST;
    endfunction

    function automatic logic is_burst(input logic [2:0] op);
        return op == CMD_READ_BURST || op == CMD_WRITE_BURST;
    endfunction

    // One tick of the pin waveform: updates the sequencer copy and returns the pin levels.
    // The command byte is byte zero; read transfers release the data pin from byte one on.
    function automatic result_t advance_pins(input tick_t t);
        result_t    r;
        logic       reading;
        logic       done;
        logic [7:0] lim;
        logic [4:0] a;
        r = '0;
        if (pin_phase == PH_GAP)
        begin
            // The tick after the final one keeps the block busy and swallows any command.
            pin_phase = PH_IDLE;
            r.busy_res = 1'b1;
            return r;
        end
        if (pin_phase == PH_IDLE && t.command >= CMD_READ_SINGLE && t.command <= CMD_WRITE_BURST)
        begin
            pin_op = t.command;
            a = is_burst(pin_op) ? BURST_ADDRESS : t.address;
            pin_shift = {1'b1, t.ram_select, a, is_read(pin_op)};
            pin_rx = '0;
            pin_tick = '0;
            pin_bit = '0;
            pin_byte = '0;
            pin_phase = PH_LOW;
        end
        if (pin_phase == PH_IDLE)
            return r;
        reading = is_read(pin_op) && pin_byte != 0;
        // A zero setting behaves as one tick per phase.
        lim = (cfg_phase_ticks == 8'd0) ? 8'd1 : cfg_phase_ticks;
        done = ({1'b0, pin_tick} + 9'd1) >= {1'b0, lim};
        r.chip_enable = 1'b1;
        r.busy_res = 1'b1;
        r.io_drive = !reading;
        r.io_out = !reading && pin_shift[0];
        if (pin_phase == PH_LOW)
        begin
            if (!done)
                pin_tick++;
            else
            begin
                // Read bits are sampled on the last low tick, just ahead of the rising edge.
                if (reading && t.io_in)
                    pin_rx[pin_bit] = 1'b1;
                pin_phase = PH_HIGH;
                pin_tick = '0;
            end
        end
        else
        begin
            r.serial_clock = 1'b1;
            if (!done)
                pin_tick++;
            else
            begin
                pin_tick = '0;
                pin_phase = PH_LOW;
                pin_shift = pin_shift >> 1;
                pin_bit++;
                if (pin_bit == 3'd0)
                begin
                    if (reading)
                    begin
                        r.read_valid = 1'b1;
                        r.read_data = pin_rx;
                        pin_rx = '0;
                    end
                    pin_byte++;
                    if (int'(pin_byte) > (is_burst(pin_op) ? BURST_BYTES : 1))
                    begin
                        r.last = 1'b1;
                        pin_phase = PH_GAP;
                        pin_op = CMD_NONE;
                    end
                    else if (!is_read(pin_op))
                    begin
                        // The next write byte is latched on the last high tick of this byte.
                        pin_shift = t.write_data;
                        r.data_taken = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Request driver: presents queued ticks, holds each until it is taken, and idles in bursts.
    always @(posedge clk)
    begin : drive_ticks
        tick_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            src_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_pins.push_back(advance_pins({command, ram_select, address,
                                                      write_data, io_in}));
            if (!in_valid || in_ready)
            begin
                if (src_gap != 0)
                begin
                    src_gap <= src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0 && $urandom_range(99) < src_idle_pct)
                begin
                    src_gap <= $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    nxt = tick_queue.pop_front();
                    command <= nxt.command;
                    ram_select <= nxt.ram_select;
                    address <= nxt.address;
                    write_data <= nxt.write_data;
                    io_in <= nxt.io_in;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: takes results with random back-pressure and checks each against the
    // oldest expectation.
    always @(posedge clk)
    begin : watch_pins
        result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            snk_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_pins.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %0h", $time,
                             {chip_enable, serial_clock, io_out, io_drive, data_taken,
                              read_valid, read_data, last, busy_res});
                    errors++;
                end
                else
                begin
                    want = expected_pins.pop_front();
                    check_field("chip_enable", 8'(want.chip_enable), 8'(chip_enable));
                    check_field("serial_clock", 8'(want.serial_clock), 8'(serial_clock));
                    check_field("io_out", 8'(want.io_out), 8'(io_out));
                    check_field("io_drive", 8'(want.io_drive), 8'(io_drive));
                    check_field("data_taken", 8'(want.data_taken), 8'(data_taken));
                    check_field("read_valid", 8'(want.read_valid), 8'(read_valid));
                    check_field("read_data", want.read_data, read_data);
                    check_field("last", 8'(want.last), 8'(last));
                    check_field("busy_res", 8'(want.busy_res), 8'(busy_res));
                end
            end
            if (snk_gap != 0)
            begin
                snk_gap <= snk_gap - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(99) < snk_idle_pct)
            begin
                snk_gap <= $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Hang detector: any handshake or bus access restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic queue_tick(input logic [2:0] cmd, input logic ram, input logic [4:0] addr,
                              input logic [7:0] wdata, input logic io);
        tick_queue.push_back({cmd, ram, addr, wdata, io});
        queued_ticks++;
    endtask

    // Ticks with random content. Quiet ones carry only commands that never start a transfer,
    // the others carry any code, which the block must ignore while busy.
    task automatic queue_filler(input int n, input logic quiet);
        int         k;
        logic [2:0] cmd;
        for (k = 0; k < n; k++)
        begin
            if (quiet)
            begin
                cmd = 3'($urandom_range(0, 3));
                cmd = (cmd == 3'd0) ? CMD_NONE : CMD_RESERVED_FIRST + cmd - 3'd1;
            end
            else
                cmd = 3'($urandom_range(CMD_NONE, CMD_RESERVED_LAST));
            queue_tick(cmd, 1'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    // A whole transfer from an idle block: the command tick, every busy tick and the gap tick.
    task automatic queue_transfer(input logic [2:0] cmd, input logic ram, input logic [4:0] addr);
        int per_phase;
        int bytes;
        per_phase = (cfg_phase_ticks == 8'd0) ? 1 : int'(cfg_phase_ticks);
        bytes = is_burst(cmd) ? BURST_BYTES : 1;
        if (is_read(cmd))
            n_reads++;
        else
            n_writes++;
        if (is_burst(cmd))
            n_bursts++;
        queue_tick(cmd, ram, addr, 8'($urandom), 1'($urandom));
        queue_filler((1 + bytes) * 16 * per_phase, 1'b0);
    endtask

    // Mostly complete transfers with random content, with short runs of idle ticks between.
    task automatic queue_random(input int budget);
        int         start;
        int         per_phase;
        int         burst_len;
        logic [2:0] cmd;
        start = queued_ticks;
        per_phase = (cfg_phase_ticks == 8'd0) ? 1 : int'(cfg_phase_ticks);
        burst_len = 1 + (1 + BURST_BYTES) * 16 * per_phase;
        while (queued_ticks - start < budget)
        begin
            if ($urandom_range(99) < 85)
            begin
                cmd = 3'($urandom_range(CMD_READ_SINGLE, CMD_WRITE_BURST));
                // A burst that would run past the remaining budget becomes a single access
                // in the same direction.
                if (is_burst(cmd) && burst_len > budget - (queued_ticks - start))
                    cmd = (cmd == CMD_READ_BURST) ? CMD_READ_SINGLE : CMD_WRITE_SINGLE;
                queue_transfer(cmd, 1'($urandom), 5'($urandom));
            end
            else
                queue_filler($urandom_range(1, 5), 1'b1);
        end
    endtask

    // Waits until every queued request is taken and every expected result has arrived.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || in_valid || expected_pins.size() != 0);
    endtask

    // Bus write of phase_ticks followed by a read-back.
    task automatic set_phase_ticks(input logic [7:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_PHASE_TICKS;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        cfg_phase_ticks = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== value)
        begin
            $display("%0t: phase_ticks read-back expected %0h, got %0h", $time, value,
                     prdata[7:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset setting of two ticks per phase. Idle ticks with no command and with the
        // unused codes, at all-zero and all-one fields, must leave every pin low.
        queue_tick(CMD_NONE, 1'b0, 5'd0, 8'h00, 1'b0);
        queue_tick(CMD_RESERVED_FIRST, 1'b0, 5'd0, 8'h00, 1'b0);
        queue_tick(CMD_RESERVED_FIRST + 3'd1, 1'b1, 5'd31, 8'hFF, 1'b1);
        queue_tick(CMD_RESERVED_LAST, 1'b1, 5'd31, 8'hFF, 1'b1);
        // Address 31 on a single access goes out as given and moves one byte.
        queue_transfer(CMD_READ_SINGLE, 1'b1, 5'd31);
        queue_transfer(CMD_WRITE_SINGLE, 1'b0, 5'd0);
        wait_idle();

        // Fastest waveform; bursts ignore the given address.
        set_phase_ticks(8'd1);
        queue_transfer(CMD_READ_BURST, 1'b0, 5'd7);
        queue_transfer(CMD_WRITE_BURST, 1'b1, 5'd30);
        queue_random(40);
        wait_idle();

        // A zero setting must behave like one.
        set_phase_ticks(8'd0);
        src_idle_pct = 0;
        snk_idle_pct = 35;
        queue_random(40);
        wait_idle();

        set_phase_ticks(8'd3);
        src_idle_pct = 35;
        snk_idle_pct = 0;
        queue_random(60);
        wait_idle();

        // Slowest setting: stop partway into the first low phase, then shorten the phase
        // while the counter already stands past the new value, so the phase ends at once.
        set_phase_ticks(8'd255);
        src_idle_pct = 15;
        snk_idle_pct = 15;
        n_reads++;
        queue_tick(CMD_READ_SINGLE, 1'b0, 5'd12, 8'h5A, 1'b1);
        queue_filler(19, 1'b0);
        wait_idle();
        set_phase_ticks(8'd1);
        while (pin_phase != PH_IDLE)
        begin
            queue_filler(8, 1'b1);
            wait_idle();
        end

        // Closing stretch at full rate on both sides.
        set_phase_ticks(8'd1);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        src_gap = 0;
        snk_gap = 0;
        queue_random(40);
        wait_idle();
        repeat (4) @(posedge clk);

        $display("Checked %0d tick results covering %0d reads and %0d writes, %0d of them bursts.",
                 results_seen, n_reads, n_writes, n_bursts);
        $display("Phase lengths used: 2, 1, 0, 3, 255 cut short to 1 mid-bit, then 1.");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
